/* src/stbs_pkg.sv */
// Shared types, codes and default sizes for the sorted table search core.
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

   // Default sizes of the key store.
   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int KEY_WIDTH_DEFAULT   = 32;

   // Fixed field widths of the words on the channels.
   localparam int ENTRY_INDEX_W = 10;
   localparam int FIELD_KEY_W   = 32;
   localparam int INDEX_W       = 12;
   localparam int LENGTH_W      = 11;

   typedef logic        [ENTRY_INDEX_W-1:0] entry_index_type;
   typedef logic signed [FIELD_KEY_W-1:0]   field_key_type;
   typedef logic signed [INDEX_W-1:0]       index_type;
   typedef logic        [LENGTH_W-1:0]      length_type;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_SEARCH = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ILLEGAL = 2'd1,
      STATUS_BOUNDS  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

/* src/stbs_req_if.sv */
// Request channel: table writes and search requests.
`timescale 1ns / 1ps
`default_nettype none

interface stbs_req_if;
   import stbs_pkg::*;

   logic            valid;
   logic            ready;
   kind_type        kind;
   entry_index_type entry_index;
   field_key_type   entry_key;
   index_type       start_index;
   index_type       end_index;
   field_key_type   search_key;

   modport source (
      output valid, kind, entry_index, entry_key, start_index, end_index, search_key,
      input  ready
   );

   modport sink (
      input  valid, kind, entry_index, entry_key, start_index, end_index, search_key,
      output ready
   );
endinterface

`default_nettype wire

/* src/stbs_rsp_if.sv */
// Response channel: search status and result index.
`timescale 1ns / 1ps
`default_nettype none

interface stbs_rsp_if;
   import stbs_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   logic       found;
   index_type  result_index;

   modport source (
      output valid, status, found, result_index,
      input  ready
   );

   modport sink (
      input  valid, status, found, result_index,
      output ready
   );
endinterface

`default_nettype wire

/* src/sorted_table_binary_search_core.sv */
// Top level: key table memory with a one-probe-per-cycle binary search engine.
`timescale 1ns / 1ps
`default_nettype none

// Sorted table binary search core. Write words (kind = write) store one signed
// key at entry_index and produce no response; the core stays idle. Search words
// check their range first (start above end: illegal argument; start below zero
// or end beyond the programmed length: out of bounds, result_index -1), then run
// a binary search over [start_index, end_index) of a table assumed ascending.
// A hit returns the probed index with found set; a miss returns the complement
// of the insertion point. The table sits in one synchronous memory with one
// write port and one read port; each probe is one memory read, and the next
// probe address is chosen in the same cycle the read data is compared. A search
// is accepted, runs its probes one after another (at most log2 of the range
// plus one) and then hands its result to the response register once that
// register is free. One word is in flight at a time; a finished response may
// wait in its register while the next request is accepted. Keys are compared as
// KEY_WIDTH-bit two's complement values taken from the low bits of the key
// fields. Entries hold no reset value: search only what has been written.
// Program table_length through csr_wen/csr_wdata only while the core is idle;
// a length above TABLE_DEPTH acts as TABLE_DEPTH.
module sorted_table_binary_search_core #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wen,
   input  wire stbs_pkg::length_type csr_wdata,
   stbs_req_if.sink                  req_port,
   stbs_rsp_if.source                rsp_port
);
   import stbs_pkg::*;

   localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WIDE_W  = 17;           // holds any depth up to 65536
   localparam int SIDX_W  = INDEX_W + 1;  // lo/hi/mid with headroom for the sum

   typedef logic signed [SIDX_W-1:0] sidx_type;

   // Take the low KEY_WIDTH bits of a key field.
   function automatic logic [KEY_WIDTH-1:0] key_trim(input logic [FIELD_KEY_W-1:0] f);
      logic [63:0] w;
      w = {32'b0, f};
      return w[KEY_WIDTH-1:0];
   endfunction

   // Memory address from a nonnegative search index.
   function automatic logic [AW-1:0] to_addr(input sidx_type m);
      logic [WIDE_W-1:0] w;
      w = {{(WIDE_W-INDEX_W){1'b0}}, m[INDEX_W-1:0]};
      return w[AW-1:0];
   endfunction

   // Complement of a search index, as a result index.
   function automatic index_type miss_index(input sidx_type m);
      sidx_type c;
      c = ~m;
      return c[INDEX_W-1:0];
   endfunction

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   length_type           length_ff;
   sidx_type             lo_ff, lo_in;
   sidx_type             hi_ff, hi_in;
   sidx_type             mid_ff, mid_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   status_type           res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   index_type            res_index_ff, res_index_in;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic                 rsp_found_ff;
   index_type            rsp_index_ff;

   // Key table: one write port, one registered read port.
   logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;
   logic [AW-1:0]        wr_addr;

   // ---------------------------------------------------------------- request decode
   logic              req_acc;
   logic              slot_free;
   logic [WIDE_W-1:0] wr_pos_wide;
   logic [WIDE_W-1:0] len_wide;
   length_type        len_clamped;
   sidx_type          len_s;
   sidx_type          start_s, end_s;
   sidx_type          mid0;
   logic              is_illegal, is_bounds, is_empty;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_port.valid && req_port.ready;
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;

   // Drop writes that fall beyond the table.
   assign wr_pos_wide = {{(WIDE_W-ENTRY_INDEX_W){1'b0}}, req_port.entry_index};
   assign wr_addr     = wr_pos_wide[AW-1:0];
   assign mem_we      = req_acc && (req_port.kind == KIND_WRITE)
                        && (wr_pos_wide < WIDE_W'(TABLE_DEPTH));

   // Clamp the programmed length to the table depth.
   assign len_wide    = {{(WIDE_W-LENGTH_W){1'b0}}, length_ff};
   assign len_clamped = (len_wide > WIDE_W'(TABLE_DEPTH)) ? LENGTH_W'(TABLE_DEPTH) : length_ff;
   assign len_s       = $signed({{(SIDX_W-LENGTH_W){1'b0}}, len_clamped});

   assign start_s    = {req_port.start_index[INDEX_W-1], req_port.start_index};
   assign end_s      = {req_port.end_index[INDEX_W-1], req_port.end_index};
   assign is_illegal = start_s > end_s;
   assign is_bounds  = (start_s < 0) || (end_s > len_s);
   assign is_empty   = start_s == end_s;
   assign mid0       = (start_s + end_s - sidx_type'(1)) >>> 1;

   // ---------------------------------------------------------------- probe compare
   logic     key_lt, key_gt;
   sidx_type mid_p1, mid_m1, mid_up, mid_dn;
   logic     cont_up, cont_dn;

   assign key_lt  = $signed(rd_data_ff) < $signed(key_ff);
   assign key_gt  = $signed(rd_data_ff) > $signed(key_ff);
   // Both candidate next probes are formed alongside the compare.
   assign mid_p1  = mid_ff + sidx_type'(1);
   assign mid_m1  = mid_ff - sidx_type'(1);
   assign mid_up  = (mid_p1 + hi_ff) >>> 1;
   assign mid_dn  = (lo_ff + mid_m1) >>> 1;
   assign cont_up = mid_ff < hi_ff;
   assign cont_dn = lo_ff < mid_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_port.kind == KIND_SEARCH)) begin
               if (is_illegal || is_bounds || is_empty) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (!key_lt && !key_gt) begin
               state_in = ST_FINISH;
            end else if (key_lt && !cont_up) begin
               state_in = ST_FINISH;
            end else if (key_gt && !cont_dn) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath controls
   always_comb begin
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      rd_addr       = to_addr(mid0);
      case (state_ff)
         ST_IDLE: begin
            // Launch the first probe while the range is checked.
            lo_in         = start_s;
            hi_in         = end_s - sidx_type'(1);
            mid_in        = mid0;
            key_in        = key_trim(req_port.search_key);
            res_status_in = STATUS_OK;
            res_found_in  = 1'b0;
            res_index_in  = miss_index(start_s);
            if (is_illegal) begin
               res_status_in = STATUS_ILLEGAL;
               res_index_in  = '1;
            end else if (is_bounds) begin
               res_status_in = STATUS_BOUNDS;
               res_index_in  = '1;
            end
         end
         ST_SEARCH: begin
            if (key_lt) begin
               // Probe too small: advance lo past mid.
               lo_in        = mid_p1;
               mid_in       = mid_up;
               rd_addr      = to_addr(mid_up);
               res_found_in = 1'b0;
               res_index_in = miss_index(mid_p1);
            end else if (key_gt) begin
               // Probe too large: pull hi below mid.
               hi_in        = mid_m1;
               mid_in       = mid_dn;
               rd_addr      = to_addr(mid_dn);
               res_found_in = 1'b0;
               res_index_in = miss_index(lo_ff);
            end else begin
               res_found_in = 1'b1;
               res_index_in = mid_ff[INDEX_W-1:0];
            end
            res_status_in = STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         length_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            length_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_index_ff  <= res_index_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_addr] <= key_trim(req_port.entry_key);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= key_mem[rd_addr];
   end

   // Response register: load the finished result once the slot frees up.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && slot_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_index_ff  <= res_index_ff;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = rsp_status_ff;
   assign rsp_port.found        = rsp_found_ff;
   assign rsp_port.result_index = rsp_index_ff;

   // ---------------------------------------------------------------- assertions
   a_range_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff <= hi_ff))
      else $error("search running on an empty range");

   a_mid_tracks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (mid_ff == ((lo_ff + hi_ff) >>> 1)))
      else $error("probe index is not the midpoint of lo and hi");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("hit reported with an error status");

endmodule

`default_nettype wire
